// ----- sv/pke_pkg.sv -----
// Shared types, constants and fixed-point helpers for the periodic kernel evaluator.
// Used by every module and interface of the block; depends on nothing.
package pke_pkg;

   localparam int MAX_DIMS   = 3;
   localparam int NUM_FIELDS = 3;

   localparam int TAU_W   = 24;
   localparam int IP_W    = 20;
   localparam int ILS_W   = 24;
   localparam int SV_W    = 32;
   localparam int OUT_W   = 32;
   localparam int PHASE_W = 28;
   localparam int TERM_W  = 39;
   localparam int Y_W     = TERM_W + 3;
   localparam int REM_W   = 35;
   localparam int Q_W     = 31;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // pipeline depths, register stages from input to output of each unit
   localparam int SIN_LAT   = 7;
   localparam int LANE_LAT  = SIN_LAT + 3;
   localparam int DIV_STEPS = 5;
   localparam int EXP_TERMS = 10;
   localparam int EXP_LAT   = 1 + DIV_STEPS + 2 * EXP_TERMS + 2;
   localparam int GRAD_LAT  = 5;
   localparam int TOTAL_LAT = LANE_LAT + EXP_LAT + GRAD_LAT;

   localparam logic signed [63:0] Q30_ONE   = 64'sd1073741824;
   localparam logic signed [63:0] SIN_C1    = 64'sd1686629713;
   localparam logic signed [63:0] SIN_C3    = -64'sd693598668;
   localparam logic signed [63:0] SIN_C5    = 64'sd85569305;
   localparam logic signed [63:0] SIN_C7    = -64'sd5026996;
   localparam logic signed [63:0] SIN_C9    = 64'sd172272;
   localparam logic signed [63:0] TWOPI_Q28 = 64'sd1686629713;
   localparam logic [63:0]        LN2_Q30   = 64'd744261118;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIM_COUNT    = 3'd0,
      CSR_SIGNAL_VAR   = 3'd1,
      CSR_INV_PERIOD_0 = 3'd2,
      CSR_INV_PERIOD_1 = 3'd3,
      CSR_INV_PERIOD_2 = 3'd4,
      CSR_INV_LSQ_0    = 3'd5,
      CSR_INV_LSQ_1    = 3'd6,
      CSR_INV_LSQ_2    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                        dim_count;
      logic [SV_W-1:0]                   signal_variance;
      logic [NUM_FIELDS-1:0][IP_W-1:0]   inv_period;
      logic [NUM_FIELDS-1:0][ILS_W-1:0]  inv_lscale_sq;
   } cfg_type;

   // Q30 product, truncated toward zero
   function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] p;
      logic signed [63:0] mag;
      begin
         p   = a * b;
         mag = p[63] ? -p : p;
         mag = mag >>> 30;
         return p[63] ? -mag : mag;
      end
   endfunction

   // ceil(2^34 / k): floor(v / k) == (v * div_recip(k)) >> 34 for any 30-bit v
   function automatic logic [34:0] div_recip(input int k);
      begin
         case (k)
            1:       return 35'd17179869184;
            2:       return 35'd8589934592;
            3:       return 35'd5726623062;
            4:       return 35'd4294967296;
            5:       return 35'd3435973837;
            6:       return 35'd2863311531;
            7:       return 35'd2454267027;
            8:       return 35'd2147483648;
            9:       return 35'd1908874354;
            10:      return 35'd1717986919;
            default: return 35'd0;
         endcase
      end
   endfunction

endpackage

// ----- sv/pke_req_if.sv -----
// Request channel of the periodic kernel evaluator: valid/ready plus the tau vector.
// Depends on pke_pkg for field widths.
interface pke_req_if import pke_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [TAU_W-1:0] tau_0;
   logic signed [TAU_W-1:0] tau_1;
   logic signed [TAU_W-1:0] tau_2;

   modport source (output valid, output tau_0, output tau_1, output tau_2, input ready);
   modport sink   (input valid, input tau_0, input tau_1, input tau_2, output ready);
endinterface

// ----- sv/pke_rsp_if.sv -----
// Response channel of the periodic kernel evaluator: kernel value and gradients.
// Depends on pke_pkg for field widths.
interface pke_rsp_if import pke_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [OUT_W-1:0]        kernel_value;
   logic signed [OUT_W-1:0] grad_0;
   logic signed [OUT_W-1:0] grad_1;
   logic signed [OUT_W-1:0] grad_2;

   modport source (output valid, output kernel_value, output grad_0, output grad_1,
                   output grad_2, input ready);
   modport sink   (input valid, input kernel_value, input grad_0, input grad_1,
                   input grad_2, output ready);
endinterface

// ----- sv/periodic_kernel_eval.sv -----
// Top level of the periodic (exp-sine-squared) kernel evaluator.
// Depends on pke_pkg, pke_req_if, pke_rsp_if, pke_lane, pke_exp and pke_grad.
//
// Usage:
//   req_chan carries one tau vector per transaction, rsp_chan returns the kernel
//   value and one gradient per dimension. Both are valid/ready channels.
//   csr_we/csr_index/csr_wdata write the configuration registers, one per cycle.
//   A transaction passes through the lanes (phase multiply, seven-stage sine
//   pipeline, square and scale), the merge stage (sum, five-step ln2 reduction,
//   ten-term exp Horner chain at two stages a term, sigma squared scaling) and
//   the gradient units.
//   Throughput is one transaction per cycle while the response is not stalled;
//   one lane per dimension runs in parallel and every stage is fully pipelined.
//   When the response is stalled the whole pipeline holds and req_chan.ready
//   drops in the same cycle; nothing is lost or repeated.
//   Reset (synchronous) empties the pipeline and loads the register defaults:
//   three dimensions, all scale registers at 1.0.
module periodic_kernel_eval import pke_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pke_req_if.sink               req_chan,
   pke_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                 cfg_ff;
   logic [TOTAL_LAT-1:0]    vld_ff;
   logic                    en;
   logic signed [TAU_W-1:0] tau_arr  [NUM_FIELDS];
   logic [TERM_W-1:0]       term_arr [MAX_DIMS];
   logic signed [31:0]      m_arr    [MAX_DIMS];
   logic signed [31:0]      m_dly_ff [MAX_DIMS][EXP_LAT];
   logic [OUT_W-1:0]        kern;
   logic [OUT_W-1:0]        kern_dly_ff [GRAD_LAT];
   logic signed [OUT_W-1:0] grad_arr [NUM_FIELDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_count       <= 2'd3;
         cfg_ff.signal_variance <= 32'd65536;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            cfg_ff.inv_period[i]    <= 20'd65536;
            cfg_ff.inv_lscale_sq[i] <= 24'd65536;
         end
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DIM_COUNT:    cfg_ff.dim_count        <= csr_wdata[1:0];
            CSR_SIGNAL_VAR:   cfg_ff.signal_variance  <= csr_wdata[SV_W-1:0];
            CSR_INV_PERIOD_0: cfg_ff.inv_period[0]    <= csr_wdata[IP_W-1:0];
            CSR_INV_PERIOD_1: cfg_ff.inv_period[1]    <= csr_wdata[IP_W-1:0];
            CSR_INV_PERIOD_2: cfg_ff.inv_period[2]    <= csr_wdata[IP_W-1:0];
            CSR_INV_LSQ_0:    cfg_ff.inv_lscale_sq[0] <= csr_wdata[ILS_W-1:0];
            CSR_INV_LSQ_1:    cfg_ff.inv_lscale_sq[1] <= csr_wdata[ILS_W-1:0];
            CSR_INV_LSQ_2:    cfg_ff.inv_lscale_sq[2] <= csr_wdata[ILS_W-1:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // whole pipeline advances unless a finished result is waiting
   assign en             = !vld_ff[TOTAL_LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_chan.valid};
      end
   end

   assign tau_arr[0] = req_chan.tau_0;
   assign tau_arr[1] = req_chan.tau_1;
   assign tau_arr[2] = req_chan.tau_2;

   for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
      pke_lane u_lane (
         .clock         (clock),
         .en            (en),
         .tau           (tau_arr[i]),
         .inv_period    (cfg_ff.inv_period[i]),
         .inv_lscale_sq (cfg_ff.inv_lscale_sq[i]),
         .term          (term_arr[i]),
         .m             (m_arr[i])
      );

      always_ff @(posedge clock) begin
         if (en) begin
            m_dly_ff[i][0] <= m_arr[i];
            for (int s = 1; s < EXP_LAT; s++) begin
               m_dly_ff[i][s] <= m_dly_ff[i][s-1];
            end
         end
      end
   end

   pke_exp u_exp (
      .clock (clock),
      .en    (en),
      .cfg   (cfg_ff),
      .term  (term_arr),
      .kern  (kern)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         kern_dly_ff[0] <= kern;
         for (int s = 1; s < GRAD_LAT; s++) begin
            kern_dly_ff[s] <= kern_dly_ff[s-1];
         end
      end
   end

   for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_grad
      if (i < MAX_DIMS) begin : g_on
         pke_grad u_grad (
            .clock         (clock),
            .en            (en),
            .active        (i < int'(cfg_ff.dim_count)),
            .kern          (kern),
            .m             (m_dly_ff[i][EXP_LAT-1]),
            .inv_period    (cfg_ff.inv_period[i]),
            .inv_lscale_sq (cfg_ff.inv_lscale_sq[i]),
            .grad          (grad_arr[i])
         );
      end else begin : g_off
         assign grad_arr[i] = '0;
      end
   end

   assign rsp_chan.valid        = vld_ff[TOTAL_LAT-1];
   assign rsp_chan.kernel_value = kern_dly_ff[GRAD_LAT-1];
   assign rsp_chan.grad_0       = grad_arr[0];
   assign rsp_chan.grad_1       = grad_arr[1];
   assign rsp_chan.grad_2       = grad_arr[2];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[TOTAL_LAT-1] && !rsp_chan.ready) |=> $stable(vld_ff))
      else $error("pipeline moved while the response was stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

// ----- sv/pke_sin.sv -----
// Pipelined sine of a 32-bit turn angle, result in Q30, seven register stages.
// Depends on pke_pkg (polynomial coefficients, mul_q30).
module pke_sin import pke_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        angle,
   output logic signed [31:0] sine
);

   logic [30:0]        t_in;
   logic [30:0]        t_dly_ff   [6];
   logic               neg_dly_ff [6];
   logic [30:0]        t2_dly_ff  [4];
   logic signed [31:0] acc_ff     [4];
   logic signed [63:0] res;
   logic signed [31:0] sine_ff;

   // fold odd quadrants onto the rising quarter wave
   always_comb begin
      t_in = {1'b0, angle[29:0]};
      if (angle[30]) begin
         t_in = 31'(Q30_ONE) - t_in;
      end
   end

   assign res = mul_q30(64'(acc_ff[3]), 64'(t_dly_ff[5]));

   always_ff @(posedge clock) begin
      if (en) begin
         t_dly_ff[0]   <= t_in;
         neg_dly_ff[0] <= angle[31];
         for (int i = 1; i < 6; i++) begin
            t_dly_ff[i]   <= t_dly_ff[i-1];
            neg_dly_ff[i] <= neg_dly_ff[i-1];
         end
         t2_dly_ff[0] <= 31'(mul_q30(64'(t_dly_ff[0]), 64'(t_dly_ff[0])));
         for (int i = 1; i < 4; i++) begin
            t2_dly_ff[i] <= t2_dly_ff[i-1];
         end
         acc_ff[0] <= 32'(SIN_C7 + mul_q30(SIN_C9, 64'(t2_dly_ff[0])));
         acc_ff[1] <= 32'(SIN_C5 + mul_q30(64'(acc_ff[0]), 64'(t2_dly_ff[1])));
         acc_ff[2] <= 32'(SIN_C3 + mul_q30(64'(acc_ff[1]), 64'(t2_dly_ff[2])));
         acc_ff[3] <= 32'(SIN_C1 + mul_q30(64'(acc_ff[2]), 64'(t2_dly_ff[3])));
         sine_ff   <= neg_dly_ff[5] ? 32'(-res) : 32'(res);
      end
   end

   assign sine = sine_ff;

endmodule

// ----- sv/pke_lane.sv -----
// One dimension lane: phase, the two sines, the scaled sin^2 term and 2*pi*sin(2*pi*f).
// Depends on pke_pkg and pke_sin.
module pke_lane import pke_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [TAU_W-1:0] tau,
   input  logic [IP_W-1:0]         inv_period,
   input  logic [ILS_W-1:0]        inv_lscale_sq,
   output logic [TERM_W-1:0]       term,
   output logic signed [31:0]      m
);

   logic signed [44:0]  phase_prod;
   logic [PHASE_W-1:0]  phase_ff;
   logic signed [31:0]  s_sq;
   logic signed [31:0]  s_grad;
   logic signed [63:0]  sq_prod;
   logic [Q_W-1:0]      sq_ff;
   logic signed [31:0]  m_ff;
   logic signed [31:0]  m_out_ff;
   logic [54:0]         term_prod;
   logic [TERM_W-1:0]   term_ff;

   assign phase_prod = 45'(tau) * $signed({25'd0, inv_period});

   always_ff @(posedge clock) begin
      if (en) begin
         phase_ff <= phase_prod[PHASE_W-1:0];
      end
   end

   pke_sin u_sin_sq (
      .clock (clock),
      .en    (en),
      .angle ({1'b0, phase_ff, 3'b000}),
      .sine  (s_sq)
   );

   pke_sin u_sin_grad (
      .clock (clock),
      .en    (en),
      .angle ({phase_ff, 4'b0000}),
      .sine  (s_grad)
   );

   assign sq_prod   = 64'(s_sq) * 64'(s_sq);
   assign term_prod = 55'(sq_ff) * 55'(inv_lscale_sq);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_prod[60:30];
         m_ff     <= 32'(mul_q30(64'(s_grad), TWOPI_Q28));
         term_ff  <= term_prod[54:16];
         m_out_ff <= m_ff;
      end
   end

   assign term = term_ff;
   assign m    = m_out_ff;

endmodule

// ----- sv/pke_exp.sv -----
// Merge stage: sums the lane terms, reduces by ln2, runs the exp(-r) Horner chain
// and scales by sigma squared. Depends on pke_pkg.
module pke_exp import pke_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  cfg_type           cfg,
   input  logic [TERM_W-1:0] term [MAX_DIMS],
   output logic [OUT_W-1:0]  kern
);

   localparam logic [Y_W-1:0] EXP_LIMIT = Y_W'(32 * LN2_Q30);
   localparam int NSTG = 2 * EXP_TERMS;

   logic [Y_W-2:0]   sum;
   logic [Y_W-1:0]   y_ff;
   logic [REM_W-1:0] rem_ff [DIV_STEPS];
   logic [4:0]       n_ff   [DIV_STEPS];
   logic             big_ff [DIV_STEPS];
   logic [29:0]      r_c_ff   [NSTG];
   logic [4:0]       n_c_ff   [NSTG];
   logic             big_c_ff [NSTG];
   logic [29:0]      v_ff     [EXP_TERMS];
   logic [Q_W-1:0]   acc_ff   [EXP_TERMS];
   logic [62:0]      prod_ff;
   logic [4:0]       n_k_ff;
   logic             big_k_ff;
   logic [62:0]      shifted;
   logic [OUT_W-1:0] kern_ff;

   always_comb begin
      sum = '0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         if (i < int'(cfg.dim_count)) begin
            sum = sum + (Y_W-1)'(term[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= {sum, 1'b0};
      end
   end

   // restoring division by ln2, one quotient bit per stage; n >= 32 flushes to zero
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam logic [REM_W-1:0] DIVISOR = REM_W'(LN2_Q30 << (DIV_STEPS - 1 - j));
      logic [REM_W-1:0] rem_src;
      logic [4:0]       n_src;
      logic             big_src;
      if (j == 0) begin : g_first
         assign rem_src = y_ff[REM_W-1:0];
         assign n_src   = '0;
         assign big_src = (y_ff >= EXP_LIMIT);
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign n_src   = n_ff[j-1];
         assign big_src = big_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            big_ff[j] <= big_src;
            if (rem_src >= DIVISOR) begin
               rem_ff[j] <= rem_src - DIVISOR;
               n_ff[j]   <= n_src | (5'd1 << (DIV_STEPS - 1 - j));
            end else begin
               rem_ff[j] <= rem_src;
               n_ff[j]   <= n_src;
            end
         end
      end
   end

   for (genvar s = 0; s < NSTG; s++) begin : g_carry
      logic [29:0] r_src;
      logic [4:0]  n_src;
      logic        big_src;
      if (s == 0) begin : g_first
         assign r_src   = rem_ff[DIV_STEPS-1][29:0];
         assign n_src   = n_ff[DIV_STEPS-1];
         assign big_src = big_ff[DIV_STEPS-1];
      end else begin : g_next
         assign r_src   = r_c_ff[s-1];
         assign n_src   = n_c_ff[s-1];
         assign big_src = big_c_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_c_ff[s]   <= r_src;
            n_c_ff[s]   <= n_src;
            big_c_ff[s] <= big_src;
         end
      end
   end

   // acc = 1 - (r*acc)/k for k = 10 down to 1, two stages per term
   for (genvar h = 0; h < EXP_TERMS; h++) begin : g_horner
      localparam logic [34:0] RECIP = div_recip(EXP_TERMS - h);
      logic [Q_W-1:0] acc_src;
      logic [29:0]    r_src;
      logic [60:0]    ra_prod;
      logic [64:0]    q_prod;
      if (h == 0) begin : g_first
         assign acc_src = Q_W'(Q30_ONE);
         assign r_src   = rem_ff[DIV_STEPS-1][29:0];
      end else begin : g_next
         assign acc_src = acc_ff[h-1];
         assign r_src   = r_c_ff[2*h-1];
      end
      assign ra_prod = 61'(r_src) * 61'(acc_src);
      assign q_prod  = 65'(v_ff[h]) * 65'(RECIP);
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[h]   <= ra_prod[59:30];
            acc_ff[h] <= Q_W'(Q30_ONE) - Q_W'(q_prod >> 34);
         end
      end
   end

   assign shifted = prod_ff >> (6'd30 + 6'(n_k_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= 63'(cfg.signal_variance) * 63'(acc_ff[EXP_TERMS-1]);
         n_k_ff   <= n_c_ff[NSTG-1];
         big_k_ff <= big_c_ff[NSTG-1];
         if (big_k_ff) begin
            kern_ff <= '0;
         end else if (|shifted[62:OUT_W]) begin
            kern_ff <= '1;
         end else begin
            kern_ff <= shifted[OUT_W-1:0];
         end
      end
   end

   assign kern = kern_ff;

endmodule

// ----- sv/pke_grad.sv -----
// Gradient of one dimension from the kernel value and 2*pi*sin(2*pi*f), saturated.
// The wide final product is split into two partial products. Depends on pke_pkg.
module pke_grad import pke_pkg::*; (
   input  logic                    clock,
   input  logic                    en,
   input  logic                    active,
   input  logic [OUT_W-1:0]        kern,
   input  logic signed [31:0]      m,
   input  logic [IP_W-1:0]         inv_period,
   input  logic [ILS_W-1:0]        inv_lscale_sq,
   output logic signed [OUT_W-1:0] grad
);

   logic [55:0]             a_prod;
   logic [39:0]             a_ff;
   logic signed [31:0]      m_ff;
   logic [59:0]             b_prod;
   logic [43:0]             b_ff;
   logic signed [31:0]      m_neg;
   logic [30:0]             mag_ff;
   logic [30:0]             mag2_ff;
   logic                    pos_ff;
   logic                    pos2_ff;
   logic                    pos3_ff;
   logic [52:0]             lo_ff;
   logic [52:0]             lo2_ff;
   logic [21:0]             bhi_ff;
   logic [52:0]             hi_ff;
   logic [74:0]             full;
   logic                    sat;
   logic [OUT_W-1:0]        q;
   logic signed [OUT_W-1:0] grad_in;
   logic signed [OUT_W-1:0] grad_ff;

   assign a_prod = 56'(kern) * 56'(inv_lscale_sq);
   assign b_prod = 60'(a_ff) * 60'(inv_period);
   assign m_neg  = -m_ff;
   assign full   = {hi_ff, 22'd0} + 75'(lo2_ff);
   assign sat    = |full[74:59];
   assign q      = sat ? {1'b1, 31'd0} : {1'b0, full[58:28]};

   always_comb begin
      if (!active) begin
         grad_in = '0;
      end else if (pos3_ff) begin
         grad_in = -$signed(q);
      end else if (sat) begin
         grad_in = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         grad_in = $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a_prod[55:16];
         m_ff    <= m;
         b_ff    <= b_prod[59:16];
         mag_ff  <= m_ff[31] ? m_neg[30:0] : m_ff[30:0];
         pos_ff  <= !m_ff[31] && (m_ff != '0);
         lo_ff   <= 53'(b_ff[21:0]) * 53'(mag_ff);
         bhi_ff  <= b_ff[43:22];
         mag2_ff <= mag_ff;
         pos2_ff <= pos_ff;
         hi_ff   <= 53'(bhi_ff) * 53'(mag2_ff);
         lo2_ff  <= lo_ff;
         pos3_ff <= pos2_ff;
         grad_ff <= grad_in;
      end
   end

   assign grad = grad_ff;

endmodule
